// ----- rtl/gtm_pkg.sv -----
// Shared types, constants and helpers for the IoU greedy track matcher.
package gtm_pkg;

    localparam int MAX_TRACKS = 32;
    localparam int IDX_W      = $clog2(MAX_TRACKS);
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        MODE_FRAME_START = 2'd0,
        MODE_DETECT      = 2'd1,
        MODE_FRAME_END   = 2'd2,
        MODE_CLEAR       = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IOU  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOST = 2'd2;

    localparam logic [16:0] MIN_IOU_RESET  = 17'd19661;
    localparam logic [15:0] MIN_HITS_RESET = 16'd3;
    localparam logic [15:0] MAX_LOST_RESET = 16'd30;

    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         class_id;
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic [14:0]        box_width;
        logic [14:0]        box_height;
    } item_t;

    typedef struct packed {
        logic [31:0] track_id;
        logic        confirmed;
        logic [15:0] track_age;
        logic        new_track;
        logic        dropped;
    } result_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_AGE,
        OP_EVICT,
        OP_CLEAR,
        OP_ISSUE,
        OP_COMMIT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

// ----- rtl/gtm_ctrl.sv -----
// Sequencer for sweeps, the clear step, the detection scan and the commit step.
module gtm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [1:0]    mode,
    output logic          busy,
    output gtm_pkg::cmd_t cmd
);
    import gtm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AGE,
        ST_EVICT,
        ST_CLEAR,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]       drain_reg, drain_next;
    logic             last;

    assign last = (idx_reg == IDX_W'(MAX_TRACKS - 1));
    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        drain_next = drain_reg;
        cmd.op     = OP_NOP;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next   = '0;
                drain_next = '0;
                if (start)
                begin
                    cmd.op = OP_LOAD;
                    unique case (mode_t'(mode))
                        MODE_FRAME_START: state_next = ST_AGE;
                        MODE_DETECT:      state_next = ST_SCAN;
                        MODE_FRAME_END:   state_next = ST_EVICT;
                        MODE_CLEAR:       state_next = ST_CLEAR;
                        default:          state_next = ST_IDLE;
                    endcase
                end
            end
            ST_AGE, ST_EVICT:
            begin
                cmd.op   = (state_reg == ST_AGE) ? OP_AGE : OP_EVICT;
                idx_next = idx_reg + 1'b1;
                if (last)
                    state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                cmd.op     = OP_CLEAR;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.op   = OP_ISSUE;
                idx_next = idx_reg + 1'b1;
                if (last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 2'd1;
                if (drain_reg == 2'd3)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.op     = OP_COMMIT;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            drain_reg <= drain_next;
        end
    end

endmodule

// ----- rtl/gtm_dp.sv -----
// Track table, configuration registers and the pipelined IoU compare unit.
module gtm_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gtm_pkg::cmd_t                 cmd,
    input  gtm_pkg::item_t                item,
    input  logic                          cfg_valid,
    input  logic [gtm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output gtm_pkg::result_t              result,
    output logic                          done
);
    import gtm_pkg::*;

    // configuration
    logic [16:0] min_iou_reg;
    logic [15:0] min_hits_reg;
    logic [15:0] max_lost_reg;

    // track table
    logic [MAX_TRACKS-1:0] valid_reg;
    logic [MAX_TRACKS-1:0] matched_reg;
    logic [31:0]           t_id    [MAX_TRACKS];
    logic [7:0]            t_class [MAX_TRACKS];
    logic signed [15:0]    t_x     [MAX_TRACKS];
    logic signed [15:0]    t_y     [MAX_TRACKS];
    logic [14:0]           t_w     [MAX_TRACKS];
    logic [14:0]           t_h     [MAX_TRACKS];
    logic [15:0]           t_age   [MAX_TRACKS];
    logic [15:0]           t_hits  [MAX_TRACKS];
    logic [15:0]           t_lost  [MAX_TRACKS];
    logic [31:0]           id_counter_reg;

    // loaded detection
    item_t       det_reg;
    logic [29:0] det_area_reg;

    // pipeline stage 1: edge distances
    logic             s1_v_reg;
    logic [14:0]      s1_dx_reg, s1_dy_reg, s1_w_reg, s1_h_reg;
    logic [31:0]      s1_id_reg;
    logic [15:0]      s1_hits_reg, s1_age_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    // stage 2: areas
    logic             s2_v_reg;
    logic [29:0]      s2_ov_reg, s2_a_reg;
    logic [31:0]      s2_id_reg;
    logic [15:0]      s2_hits_reg, s2_age_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    // stage 3: union
    logic             s3_v_reg;
    logic [29:0]      s3_ov_reg;
    logic [30:0]      s3_un_reg;
    logic [31:0]      s3_id_reg;
    logic [15:0]      s3_hits_reg, s3_age_reg;
    logic [IDX_W-1:0] s3_idx_reg;
    // stage 4: threshold passed
    logic             s4_v_reg;
    logic [29:0]      s4_ov_reg;
    logic [30:0]      s4_un_reg;
    logic [31:0]      s4_id_reg;
    logic [15:0]      s4_hits_reg, s4_age_reg;
    logic [IDX_W-1:0] s4_idx_reg;

    // running best and first free slot
    logic             best_found_reg;
    logic [29:0]      best_ov_reg;
    logic [30:0]      best_un_reg;
    logic [31:0]      best_id_reg;
    logic [15:0]      best_hits_reg, best_age_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    result_t result_reg, result_next;
    logic    done_reg, done_next;

    // stage 0 comb
    logic               elig;
    logic signed [15:0] x1, y1;
    logic signed [16:0] ra, rb, ba, bb, x2, y2;
    logic signed [17:0] ddx, ddy;
    logic [14:0]        dx0, dy0;
    // stage 2 comb
    logic [30:0]        un2;
    // stage 3 comb
    logic [47:0]        thr_prod;
    logic               thr_pass;
    // stage 4 comb
    logic [60:0]        lhs, rhs;
    logic               take;
    logic [15:0]        hits_inc;

    assign result = result_reg;
    assign done   = done_reg;

    // Stage 0: box edges against the slot under the scan index.
    always_comb
    begin
        elig = valid_reg[cmd.idx] && !matched_reg[cmd.idx]
               && (t_class[cmd.idx] == det_reg.class_id);
        x1   = (t_x[cmd.idx] > det_reg.box_x) ? t_x[cmd.idx] : det_reg.box_x;
        y1   = (t_y[cmd.idx] > det_reg.box_y) ? t_y[cmd.idx] : det_reg.box_y;
        ra   = {t_x[cmd.idx][15], t_x[cmd.idx]} + {2'b00, t_w[cmd.idx]};
        rb   = {det_reg.box_x[15], det_reg.box_x} + {2'b00, det_reg.box_width};
        ba   = {t_y[cmd.idx][15], t_y[cmd.idx]} + {2'b00, t_h[cmd.idx]};
        bb   = {det_reg.box_y[15], det_reg.box_y} + {2'b00, det_reg.box_height};
        x2   = (ra < rb) ? ra : rb;
        y2   = (ba < bb) ? ba : bb;
        ddx  = {x2[16], x2} - {{2{x1[15]}}, x1};
        ddy  = {y2[16], y2} - {{2{y1[15]}}, y1};
        dx0  = (ddx > 18'sd0) ? ddx[14:0] : 15'd0;
        dy0  = (ddy > 18'sd0) ? ddy[14:0] : 15'd0;
    end

    // Stage 2 union, stage 3 threshold, stage 4 best compare.
    always_comb
    begin
        un2      = 31'(s2_a_reg) + 31'(det_area_reg) - 31'(s2_ov_reg);
        thr_prod = 48'(min_iou_reg) * 48'(s3_un_reg);
        thr_pass = ({s3_ov_reg, 16'h0000} >= 46'(thr_prod)) && (thr_prod[47:46] == 2'b00);
        lhs      = 61'(s4_ov_reg) * 61'(best_un_reg);
        rhs      = 61'(best_ov_reg) * 61'(s4_un_reg);
        take     = s4_v_reg && (!best_found_reg || (lhs > rhs)
                   || ((lhs == rhs) && (s4_id_reg > best_id_reg)));
        hits_inc = sat_inc16(best_hits_reg);
    end

    // Commit: build the result for a detection.
    always_comb
    begin
        result_next = result_reg;
        done_next   = 1'b0;
        if (cmd.op == OP_COMMIT)
        begin
            done_next = 1'b1;
            if (best_found_reg)
            begin
                result_next.confirmed = (hits_inc >= min_hits_reg);
                result_next.track_id  = result_next.confirmed ? best_id_reg : 32'd0;
                result_next.track_age = best_age_reg;
                result_next.new_track = 1'b0;
                result_next.dropped   = 1'b0;
            end
            else if (free_found_reg)
            begin
                result_next.confirmed = (16'd1 >= min_hits_reg);
                result_next.track_id  = result_next.confirmed ? id_counter_reg : 32'd0;
                result_next.track_age = 16'd1;
                result_next.new_track = 1'b1;
                result_next.dropped   = 1'b0;
            end
            else
            begin
                result_next = '0;
                result_next.dropped = 1'b1;
            end
        end
    end

    // Control state: configuration, flags, valid bits of the pipe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_iou_reg    <= MIN_IOU_RESET;
            min_hits_reg   <= MIN_HITS_RESET;
            max_lost_reg   <= MAX_LOST_RESET;
            valid_reg      <= '0;
            matched_reg    <= '0;
            id_counter_reg <= 32'd1;
            s1_v_reg       <= 1'b0;
            s2_v_reg       <= 1'b0;
            s3_v_reg       <= 1'b0;
            s4_v_reg       <= 1'b0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_MIN_IOU:  min_iou_reg  <= cfg_data[16:0];
                    CFG_MIN_HITS: min_hits_reg <= cfg_data[15:0];
                    CFG_MAX_LOST: max_lost_reg <= cfg_data[15:0];
                    default:      ;
                endcase
            end
            s1_v_reg <= (cmd.op == OP_ISSUE) && elig;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg && thr_pass;
            done_reg <= done_next;
            if (take)
                best_found_reg <= 1'b1;
            unique case (cmd.op)
                OP_LOAD:
                begin
                    best_found_reg <= 1'b0;
                    free_found_reg <= 1'b0;
                end
                OP_AGE:   matched_reg[cmd.idx] <= 1'b0;
                OP_EVICT:
                begin
                    if (t_lost[cmd.idx] > max_lost_reg)
                        valid_reg[cmd.idx] <= 1'b0;
                end
                OP_CLEAR:
                begin
                    valid_reg      <= '0;
                    matched_reg    <= '0;
                    id_counter_reg <= 32'd1;
                end
                OP_ISSUE:
                begin
                    if (!valid_reg[cmd.idx] && !free_found_reg)
                        free_found_reg <= 1'b1;
                end
                OP_COMMIT:
                begin
                    if (best_found_reg)
                        matched_reg[best_idx_reg] <= 1'b1;
                    else if (free_found_reg)
                    begin
                        valid_reg[free_idx_reg]   <= 1'b1;
                        matched_reg[free_idx_reg] <= 1'b1;
                        if (id_counter_reg != 32'hFFFF_FFFF)
                            id_counter_reg <= id_counter_reg + 32'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload: table contents, pipe data, result.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        s1_dx_reg   <= dx0;
        s1_dy_reg   <= dy0;
        s1_w_reg    <= t_w[cmd.idx];
        s1_h_reg    <= t_h[cmd.idx];
        s1_id_reg   <= t_id[cmd.idx];
        s1_hits_reg <= t_hits[cmd.idx];
        s1_age_reg  <= t_age[cmd.idx];
        s1_idx_reg  <= cmd.idx;
        s2_ov_reg   <= 30'(s1_dx_reg) * 30'(s1_dy_reg);
        s2_a_reg    <= 30'(s1_w_reg) * 30'(s1_h_reg);
        s2_id_reg   <= s1_id_reg;
        s2_hits_reg <= s1_hits_reg;
        s2_age_reg  <= s1_age_reg;
        s2_idx_reg  <= s1_idx_reg;
        // empty union counts as zero overlap over one
        s3_ov_reg   <= (un2 == 31'd0) ? 30'd0 : s2_ov_reg;
        s3_un_reg   <= (un2 == 31'd0) ? 31'd1 : un2;
        s3_id_reg   <= s2_id_reg;
        s3_hits_reg <= s2_hits_reg;
        s3_age_reg  <= s2_age_reg;
        s3_idx_reg  <= s2_idx_reg;
        s4_ov_reg   <= s3_ov_reg;
        s4_un_reg   <= s3_un_reg;
        s4_id_reg   <= s3_id_reg;
        s4_hits_reg <= s3_hits_reg;
        s4_age_reg  <= s3_age_reg;
        s4_idx_reg  <= s3_idx_reg;
        if (take)
        begin
            best_ov_reg   <= s4_ov_reg;
            best_un_reg   <= s4_un_reg;
            best_id_reg   <= s4_id_reg;
            best_hits_reg <= s4_hits_reg;
            best_age_reg  <= s4_age_reg;
            best_idx_reg  <= s4_idx_reg;
        end
        if ((cmd.op == OP_ISSUE) && !valid_reg[cmd.idx] && !free_found_reg)
            free_idx_reg <= cmd.idx;
        unique case (cmd.op)
            OP_LOAD:
            begin
                det_reg      <= item;
                det_area_reg <= 30'(item.box_width) * 30'(item.box_height);
            end
            OP_AGE:
            begin
                if (valid_reg[cmd.idx])
                begin
                    t_age[cmd.idx]  <= sat_inc16(t_age[cmd.idx]);
                    t_lost[cmd.idx] <= sat_inc16(t_lost[cmd.idx]);
                end
            end
            OP_COMMIT:
            begin
                if (best_found_reg)
                begin
                    t_x[best_idx_reg]    <= det_reg.box_x;
                    t_y[best_idx_reg]    <= det_reg.box_y;
                    t_w[best_idx_reg]    <= det_reg.box_width;
                    t_h[best_idx_reg]    <= det_reg.box_height;
                    t_lost[best_idx_reg] <= 16'd0;
                    t_hits[best_idx_reg] <= hits_inc;
                end
                else if (free_found_reg)
                begin
                    t_id[free_idx_reg]    <= id_counter_reg;
                    t_class[free_idx_reg] <= det_reg.class_id;
                    t_x[free_idx_reg]     <= det_reg.box_x;
                    t_y[free_idx_reg]     <= det_reg.box_y;
                    t_w[free_idx_reg]     <= det_reg.box_width;
                    t_h[free_idx_reg]     <= det_reg.box_height;
                    t_age[free_idx_reg]   <= 16'd1;
                    t_hits[free_idx_reg]  <= 16'd1;
                    t_lost[free_idx_reg]  <= 16'd0;
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/iou_greedy_track_matcher.sv -----
// Top level of the IoU greedy track matcher.
// A command is taken when start is high and busy is low. Frame start and
// frame end each sweep the track table one slot a cycle; clear empties the
// table in one step. A detection scans every slot through a five-stage IoU
// compare pipeline fed one slot a cycle, drains the pipeline and commits.
// Each detection gives one result on result, with done high for exactly
// one cycle; the receiver cannot stall, so capture it then. Configuration
// writes are always ready and are to be issued only while busy is low.
module iou_greedy_track_matcher (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  gtm_pkg::item_t                item,
    output gtm_pkg::result_t              result,
    output logic                          done,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gtm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import gtm_pkg::*;

    cmd_t cmd;

    // the register file takes a write transaction every cycle
    assign cfg_ready = 1'b1;

    gtm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (item.mode),
        .busy  (busy),
        .cmd   (cmd)
    );

    gtm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result),
        .done      (done)
    );

endmodule

// ----- rtl/gtm_checker.sv -----
// Port-level checks for the track matcher, bound to the top level.
module gtm_assert (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input gtm_pkg::result_t result
);
    import gtm_pkg::*;

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after a command");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_dropped_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.dropped |-> result.track_id == 32'd0 && !result.new_track
            && !result.confirmed)
        else $error("dropped result carries a track");

endmodule

bind iou_greedy_track_matcher gtm_assert u_gtm_assert (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
